// ===== sv/spq_pkg.sv =====
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 16;
    localparam int COUNT_W = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = OUT_DATA_W - (2 * COUNT_W + VALUE_W + RANK_W);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [RANK_W-1:0]  rank_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_DUMP   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_NO_HIT  = 2'd2,
        STATUS_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_MARK,
        OP_COMPACT,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_REPORT,
        ST_DUMP
    } state_t;

    typedef struct packed {
        cell_op_t op;
        value_t   value;
        rank_t    rank;
    } cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic              occupied,
    input  logic              tail,
    input  logic              prev_lt,
    input  spq_pkg::value_t   prev_value,
    input  spq_pkg::rank_t    prev_rank,
    input  logic              prev_hole,
    input  spq_pkg::value_t   next_value,
    input  spq_pkg::rank_t    next_rank,
    input  logic              next_hole,
    input  spq_pkg::value_t   head_value,
    input  spq_pkg::rank_t    head_rank,
    output spq_pkg::value_t   value,
    output spq_pkg::rank_t    rank,
    output logic              lt,
    output logic              match,
    output logic              hole
);
    import spq_pkg::*;

    value_t value_reg;
    value_t value_next;
    rank_t  rank_reg;
    rank_t  rank_next;
    logic   hole_reg;
    logic   hole_next;

    assign lt    = occupied && (rank_reg < cmd.rank);
    assign match = occupied && (value_reg == cmd.value);
    assign value = value_reg;
    assign rank  = rank_reg;
    assign hole  = hole_reg;

    always_comb
    begin
        value_next = value_reg;
        rank_next  = rank_reg;
        hole_next  = hole_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                // the new entry lands where the strictly-lower run ends; the rest shift up
                if (!lt)
                begin
                    if (prev_lt)
                    begin
                        value_next = cmd.value;
                        rank_next  = cmd.rank;
                    end
                    else
                    begin
                        value_next = prev_value;
                        rank_next  = prev_rank;
                    end
                end
            end
            OP_MARK:
            begin
                hole_next = !occupied || match;
            end
            OP_COMPACT:
            begin
                // a hole pulls its upper neighbour down; a kept entry pulled below becomes a hole
                if (hole_reg)
                begin
                    value_next = next_value;
                    rank_next  = next_rank;
                    hole_next  = next_hole;
                end
                else
                begin
                    hole_next = prev_hole;
                end
            end
            OP_ROTATE:
            begin
                if (tail)
                begin
                    value_next = head_value;
                    rank_next  = head_rank;
                end
                else
                begin
                    value_next = next_value;
                    rank_next  = next_rank;
                end
            end
            OP_HOLD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rank_reg  <= rank_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hole_reg <= 1'b0;
        else
            hole_reg <= hole_next;
    end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Channel  Dir  Handshake                   Payload
// s_       in   s_tvalid / s_tready         s_tuser: kind; s_tdata: item_value, item_rank
// m_       out  m_tvalid / m_tready         m_tuser: status; m_tdata: removed_count,
//                                           out_value, out_rank, occupancy; m_tlast: last
//
// Insert and clear update the cell row when the word is taken; one word is taken per cycle
// while idle and the output is not stalled. Remove marks matches when the word is taken, then
// compacts the row, then reports. Dump rotates the occupied cells one place per delivered word.
// Reset clears the count and control state only; slot contents are left as they are.
// A stalled output holds the row and the input; no new word is taken until the result
// register can be freed.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata,   // item_value, item_rank
    input  logic [1:0]                     s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata,   // removed_count, out_value, out_rank,
                                                      // occupancy, zero pad
    output logic [1:0]                     m_tuser,   // status
    output logic                           m_tlast
);
    import spq_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = $clog2(2 * DEPTH);

    state_t          state_reg;
    state_t          state_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic [FW-1:0]   gone_reg;
    logic [FW-1:0]   gone_next;
    logic [DEPTH-1:0] mask_reg;
    logic [DEPTH-1:0] mask_next;

    logic            m_valid_reg;
    logic            m_valid_next;
    status_t         status_reg;
    status_t         status_next;
    count_t          removed_reg;
    count_t          removed_next;
    value_t          value_reg;
    value_t          value_next;
    rank_t           rank_reg;
    rank_t           rank_next;
    count_t          occ_reg;
    count_t          occ_next;
    logic            last_reg;
    logic            last_next;

    cell_cmd_t       cmd;
    kind_t           in_kind;
    value_t          in_value;
    rank_t           in_rank;
    logic            s_acc;
    logic            out_free;
    logic            full;
    logic            dump_end;
    logic            remove_end;
    logic [FW-1:0]   fill_left;

    value_t          cell_value [DEPTH];
    rank_t           cell_rank  [DEPTH];
    logic [DEPTH-1:0] cell_lt;
    logic [DEPTH-1:0] cell_match;
    logic [DEPTH-1:0] cell_hole;
    logic [DEPTH-1:0] occ_vec;
    logic [DEPTH-1:0] tail_vec;

    assign in_kind  = kind_t'(s_tuser);
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_rank  = s_tdata[VALUE_W+RANK_W-1:VALUE_W];

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign s_acc      = s_tvalid && s_tready;
    assign full       = (fill_reg == FW'(DEPTH));
    assign dump_end   = (CW'(cnt_reg + 1'b1) == CW'(fill_reg));
    assign remove_end = (cnt_reg == CW'(2 * DEPTH - 1));
    assign fill_left  = fill_reg - gone_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic   p_lt;
            logic   p_hole;
            logic   n_hole;
            value_t p_value;
            value_t n_value;
            rank_t  p_rank;
            rank_t  n_rank;

            assign occ_vec[g]  = (FW'(g) < fill_reg);
            assign tail_vec[g] = (FW'(g + 1) == fill_reg);

            if (g == 0)
            begin : g_first
                assign p_lt    = 1'b1;
                assign p_hole  = 1'b0;
                assign p_value = '0;
                assign p_rank  = '0;
            end
            else
            begin : g_inner_lo
                assign p_lt    = cell_lt[g-1];
                assign p_hole  = cell_hole[g-1];
                assign p_value = cell_value[g-1];
                assign p_rank  = cell_rank[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign n_hole  = 1'b1;
                assign n_value = '0;
                assign n_rank  = '0;
            end
            else
            begin : g_inner_hi
                assign n_hole  = cell_hole[g+1];
                assign n_value = cell_value[g+1];
                assign n_rank  = cell_rank[g+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .occupied   (occ_vec[g]),
                .tail       (tail_vec[g]),
                .prev_lt    (p_lt),
                .prev_value (p_value),
                .prev_rank  (p_rank),
                .prev_hole  (p_hole),
                .next_value (n_value),
                .next_rank  (n_rank),
                .next_hole  (n_hole),
                .head_value (cell_value[0]),
                .head_rank  (cell_rank[0]),
                .value      (cell_value[g]),
                .rank       (cell_rank[g]),
                .lt         (cell_lt[g]),
                .match      (cell_match[g]),
                .hole       (cell_hole[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && in_kind == KIND_REMOVE)
                    state_next = ST_REMOVE;
                else if (s_acc && in_kind == KIND_DUMP && fill_reg != '0)
                    state_next = ST_DUMP;
            end
            ST_REMOVE:
            begin
                if (remove_end)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (out_free && dump_end)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // cell commands, counters and result loads
    always_comb
    begin
        cmd.op       = OP_HOLD;
        cmd.value    = in_value;
        cmd.rank     = in_rank;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        gone_next    = gone_reg;
        mask_next    = mask_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        removed_next = removed_reg;
        value_next   = value_reg;
        rank_next    = rank_reg;
        occ_next     = occ_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    removed_next = '0;
                    value_next   = '0;
                    rank_next    = '0;
                    last_next    = 1'b1;
                    status_next  = STATUS_OK;
                    occ_next     = COUNT_W'(fill_reg);
                    cnt_next     = '0;
                    case (in_kind)
                        KIND_INSERT:
                        begin
                            m_valid_next = 1'b1;
                            if (full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                cmd.op    = OP_INSERT;
                                fill_next = FW'(fill_reg + 1'b1);
                                occ_next  = COUNT_W'(FW'(fill_reg + 1'b1));
                            end
                        end
                        KIND_REMOVE:
                        begin
                            cmd.op    = OP_MARK;
                            mask_next = cell_match;
                            gone_next = '0;
                        end
                        KIND_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                m_valid_next = 1'b1;
                                status_next  = STATUS_EMPTY;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            m_valid_next = 1'b1;
                            fill_next    = '0;
                            occ_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REMOVE:
            begin
                cmd.op    = OP_COMPACT;
                gone_next = FW'(gone_reg + FW'(mask_reg[0]));
                mask_next = mask_reg >> 1;
                cnt_next  = CW'(cnt_reg + 1'b1);
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    status_next  = (gone_reg == '0) ? STATUS_NO_HIT : STATUS_OK;
                    removed_next = COUNT_W'(gone_reg);
                    value_next   = '0;
                    rank_next    = '0;
                    occ_next     = COUNT_W'(fill_left);
                    last_next    = 1'b1;
                    fill_next    = fill_left;
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    cmd.op       = OP_ROTATE;
                    m_valid_next = 1'b1;
                    status_next  = STATUS_OK;
                    removed_next = '0;
                    value_next   = cell_value[0];
                    rank_next    = cell_rank[0];
                    occ_next     = COUNT_W'(fill_reg);
                    last_next    = dump_end;
                    cnt_next     = CW'(cnt_reg + 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            gone_reg    <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            gone_reg    <= gone_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        value_reg   <= value_next;
        rank_reg    <= rank_next;
        occ_reg     <= occ_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, occ_reg, rank_reg, value_reg, removed_reg};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && in_kind == KIND_INSERT && !full) |=> fill_reg == FW'($past(fill_reg) + 1'b1))
        else $error("insert did not grow the queue");

    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP && out_free && dump_end)
        |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("dump did not finish with a last word");
`endif

endmodule
